FILE: hdl/hidt_pkg.sv
package hidt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned ID_BASE_DEF     = 1;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned TYPE_W   = 4;
  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned EXTRA_W  = 64;
  localparam int unsigned LIVE_W   = 11;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e                 operation;
    logic [TYPE_W-1:0]   object_type;
    logic [HANDLE_W-1:0] object_handle;
    logic [EXTRA_W-1:0]  extra_word;
    logic [ID_W-1:0]     object_id;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [ID_W-1:0]     result_id;
    logic [TYPE_W-1:0]   result_type;
    logic [HANDLE_W-1:0] result_handle;
    logic [EXTRA_W-1:0]  result_extra;
    logic                result_occupied;
    logic [LIVE_W-1:0]   live_entries;
  } res_t;

  typedef struct packed {
    logic                occupied;
    logic [TYPE_W-1:0]   obj_type;
    logic [HANDLE_W-1:0] obj_handle;
    logic [EXTRA_W-1:0]  obj_extra;
  } slot_t;

endpackage

FILE: hdl/hidt_ctrl.sv
module hidt_ctrl import hidt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned ID_BASE     = ID_BASE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [16:0]   BASE17   = 17'(ID_BASE);
  localparam logic [16:0]   DEPTH17  = 17'(TABLE_DEPTH);

  // Slot store, one entry per slot; cleared by a sweep after reset.
  slot_t mem [TABLE_DEPTH];
  slot_t rdata_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  slot_t         mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  state_e state_q, state_d;
  op_e                 op_q, op_d;
  logic [TYPE_W-1:0]   typ_q, typ_d;
  logic [HANDLE_W-1:0] hnd_q, hnd_d;
  logic [EXTRA_W-1:0]  ext_q, ext_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] issued_q, issued_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] last_q, last_d;
  logic [CW-1:0] count_q, count_d;
  res_t          res_q, res_d;

  logic [16:0]   id_diff;
  logic          id_ok;
  logic [IW-1:0] id_idx;
  logic          is_full;
  logic          hit;
  logic          scan_done;
  logic [IW-1:0] res_idx;
  logic [16:0]   res_id_sum;

  assign id_diff   = {1'b0, req_i.object_id} - BASE17;
  assign id_ok     = !id_diff[16] && (id_diff < DEPTH17);
  assign id_idx    = id_diff[IW-1:0];
  assign is_full   = (count_q >= DEPTH_C);
  assign hit       = rd_vld_q && ((op_q == OP_ALLOC) ? !rdata_q.occupied :
                     (rdata_q.occupied && (rdata_q.obj_type == typ_q) &&
                      (rdata_q.obj_handle == hnd_q)));
  assign scan_done = !rd_vld_q && (issued_q == DEPTH_C);
  assign res_idx   = (state_q == ST_READ) ? idx_q : rd_idx_q;
  assign res_id_sum = 17'(res_idx) + BASE17;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (ptr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          case (req_i.operation)
            OP_ALLOC:  state_d = is_full ? ST_RESP : ST_SCAN;
            OP_FIND:   state_d = ST_SCAN;
            default:   state_d = id_ok ? ST_READ : ST_RESP;
          endcase
        end
      end
      ST_READ: state_d = ST_RESP;
      ST_SCAN: begin
        if (hit || scan_done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = ptr_q;
    mem_raddr   = ptr_q;
    mem_wdata   = '0;
    op_d        = op_q;
    typ_d       = typ_q;
    hnd_d       = hnd_q;
    ext_d       = ext_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    issued_d    = issued_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    last_d      = last_q;
    count_d     = count_q;
    res_d       = res_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d     = req_i.operation;
          typ_d    = req_i.object_type;
          hnd_d    = req_i.object_handle;
          ext_d    = req_i.extra_word;
          idx_d    = id_idx;
          issued_d = '0;
          res_d              = '0;
          res_d.status       = 1'b1;
          res_d.live_entries = LIVE_W'(count_q);
          case (req_i.operation)
            OP_ALLOC: ptr_d = (last_q == LAST_IDX) ? '0 : last_q + 1'b1;
            OP_FIND:  ptr_d = '0;
            default: begin
              mem_re    = id_ok;
              mem_raddr = id_idx;
            end
          endcase
        end
      end
      ST_READ: begin
        if (op_q == OP_DELETE) begin
          if (rdata_q.occupied) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q;
            count_d   = count_q - 1'b1;
            res_d.status          = 1'b0;
            res_d.result_id       = res_id_sum[15:0];
            res_d.result_type     = rdata_q.obj_type;
            res_d.result_handle   = rdata_q.obj_handle;
            res_d.result_extra    = rdata_q.obj_extra;
            res_d.result_occupied = 1'b0;
            res_d.live_entries    = LIVE_W'(count_q - 1'b1);
          end
        end else begin
          res_d.status          = 1'b0;
          res_d.result_id       = res_id_sum[15:0];
          res_d.result_type     = rdata_q.obj_type;
          res_d.result_handle   = rdata_q.obj_handle;
          res_d.result_extra    = rdata_q.obj_extra;
          res_d.result_occupied = rdata_q.occupied;
        end
      end
      ST_SCAN: begin
        // One read is issued per cycle; its data is checked in the cycle after.
        mem_re   = (issued_q != DEPTH_C);
        rd_vld_d = mem_re;
        rd_idx_d = ptr_q;
        if (mem_re) begin
          ptr_d    = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
          issued_d = issued_q + 1'b1;
        end
        if (hit) begin
          res_d.status          = 1'b0;
          res_d.result_id       = res_id_sum[15:0];
          res_d.result_occupied = 1'b1;
          if (op_q == OP_ALLOC) begin
            mem_we               = 1'b1;
            mem_waddr            = rd_idx_q;
            mem_wdata.occupied   = 1'b1;
            mem_wdata.obj_type   = typ_q;
            mem_wdata.obj_handle = hnd_q;
            mem_wdata.obj_extra  = ext_q;
            last_d               = rd_idx_q;
            count_d              = count_q + 1'b1;
            res_d.result_type    = typ_q;
            res_d.result_handle  = hnd_q;
            res_d.result_extra   = ext_q;
            res_d.live_entries   = LIVE_W'(count_q + 1'b1);
          end else begin
            res_d.result_type   = rdata_q.obj_type;
            res_d.result_handle = rdata_q.obj_handle;
            res_d.result_extra  = rdata_q.obj_extra;
          end
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ptr_q    <= '0;
      issued_q <= '0;
      rd_vld_q <= 1'b0;
      last_q   <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      issued_q <= issued_d;
      rd_vld_q <= rd_vld_d;
      last_q   <= last_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    typ_q    <= typ_d;
    hnd_q    <= hnd_d;
    ext_q    <= ext_d;
    idx_q    <= idx_d;
    rd_idx_q <= rd_idx_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: hdl/hidt_outreg.sv
module hidt_outreg import hidt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  output logic res_ready_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic valid_q, valid_d;
  res_t data_q;

  // A new result may be loaded whenever the register is empty or the held one leaves in this cycle.
  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) valid_d = res_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) data_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

FILE: hdl/handle_id_table.sv
// Handle table with next-fit id allocation.
// The slave side takes one request beat: tuser is the operation (allocate,
// delete, get, find), tdata carries type, handle, extra word and id. The
// master side returns exactly one result beat per request: tuser is the
// status bit (0 success, 1 failure), tdata the id, slot contents, occupied
// flag and live entry count.
// One request is in work at a time. Delete and get of an id in range read a
// single slot: the read is issued when the request is taken, the result is
// built in the read state and presented from the response state; an id out
// of range, or an allocate on a full table, goes straight to the response
// state. Allocate and find walk the slot memory, one slot per cycle through
// its single read port, and stop at the first slot that fits; a find that
// misses walks the whole table. The controller returns to idle and takes the
// next request once a result moves to the output register.
// After reset the slot memory is cleared by a sweep over every slot,
// during which no request is taken.
// A result waits in an output register; while the master side stalls, the
// next request is still accepted and worked on, and it holds back only when
// its own result is ready and the register is still occupied.
module handle_id_table import hidt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned ID_BASE     = ID_BASE_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // object_type [3:0], object_handle [67:4], extra_word [131:68],
  // object_id [147:132], zero fill [151:148]
  input  logic [151:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_id [15:0], result_type [19:16], result_handle [83:20],
  // result_extra [147:84], result_occupied [148], live_entries [159:149]
  output logic [159:0] m_axis_tdata,
  // status [0]
  output logic [0:0]   m_axis_tuser
);

  req_t req;
  res_t res, out;
  logic res_valid, res_ready;

  assign req.operation     = op_e'(s_axis_tuser);
  assign req.object_type   = s_axis_tdata[3:0];
  assign req.object_handle = s_axis_tdata[67:4];
  assign req.extra_word    = s_axis_tdata[131:68];
  assign req.object_id     = s_axis_tdata[147:132];

  hidt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BASE     (ID_BASE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  hidt_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tuser[0]        = out.status;
  assign m_axis_tdata[15:0]     = out.result_id;
  assign m_axis_tdata[19:16]    = out.result_type;
  assign m_axis_tdata[83:20]    = out.result_handle;
  assign m_axis_tdata[147:84]   = out.result_extra;
  assign m_axis_tdata[148]      = out.result_occupied;
  assign m_axis_tdata[159:149]  = out.live_entries;

endmodule
